### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, quiet while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: when the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Types, codes and character constants for the text console cursor writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam int COLUMNS_DEF   = 80;
    localparam int ROW_COUNT_DEF = 25;

    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int NUM_W      = 32;
    localparam int DIGITS_MAX = 10;

    typedef logic [1:0]       func_t;
    typedef logic [7:0]       byte_t;
    typedef logic [3:0]       nib_t;
    typedef logic [ROW_W-1:0] row_t;
    typedef logic [COL_W-1:0] col_t;

    localparam func_t FUNC_PUT   = 2'd0;
    localparam func_t FUNC_HEX   = 2'd1;
    localparam func_t FUNC_DEC   = 2'd2;
    localparam func_t FUNC_CLEAR = 2'd3;

    localparam byte_t CH_TAB   = 8'd9;
    localparam byte_t CH_NL    = 8'd10;
    localparam byte_t CH_CR    = 8'd13;
    localparam byte_t CH_SPACE = 8'd32;
    localparam byte_t CH_ZERO  = 8'h30;
    localparam byte_t CH_X     = 8'h78;

    localparam byte_t ATTR_RESET = 8'd7;

    localparam byte_t HEX_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // ASCII for one digit; decimal digits use the first ten entries of the table.
    function automatic byte_t digit_char(nib_t d);
        return HEX_CHARS[d];
    endfunction

endpackage

### rtl/tccw_cmd_if.sv
// ----------------------------------------------------------------------------
// tccw_cmd_if
// Command channel: valid/ready handshake carrying one console command word.
// ----------------------------------------------------------------------------
interface tccw_cmd_if;
    import tccw_pkg::*;

    logic               valid;
    logic               ready;
    func_t              func;
    byte_t              char_code;
    nib_t               fg;
    nib_t               bg;
    logic [NUM_W-1:0]   number;

    modport source (output valid, func, char_code, fg, bg, number, input ready);
    modport sink   (input valid, func, char_code, fg, bg, number, output ready);

endinterface

### rtl/tccw_disp_if.sv
// ----------------------------------------------------------------------------
// tccw_disp_if
// Display channel: valid/ready handshake carrying one cell-write word.
// ----------------------------------------------------------------------------
interface tccw_disp_if;
    import tccw_pkg::*;

    logic   valid;
    logic   ready;
    logic   write_valid;
    row_t   row;
    col_t   col;
    byte_t  glyph;
    byte_t  attr;
    logic   scrolled;
    logic   cleared;
    logic   last;

    modport source (output valid, write_valid, row, col, glyph, attr, scrolled,
                    cleared, last, input ready);
    modport sink   (input valid, write_valid, row, col, glyph, attr, scrolled,
                    cleared, last, output ready);

endinterface

### rtl/text_console_cursor_writer.sv
// ----------------------------------------------------------------------------
// text_console_cursor_writer
// Cursor engine for a character console; emits cell writes, scrolls, clears.
// ----------------------------------------------------------------------------
// Takes one command word at a time and turns it into one or more cell-write
// words on the display channel; the cell store itself sits downstream and
// applies the writes, scrolls and clears flagged here. Put-character and
// clear load their one word into the output register in the accepting
// cycle. A hex print loads the 32-bit value as eight nibbles, drops
// leading zero nibbles at one per cycle (up to 7), then sends "0x" and the
// digits at one word per cycle; each nibble dropped is one word fewer. A
// decimal print runs a bit-serial binary-to-BCD conversion, one bit of the
// value per cycle, drops leading zero digits at one per cycle, then moves
// on and sends the remaining digits. The sending rates hold while the
// display side takes every word at once; a stall simply holds the
// sequencer. The next command is taken once the last word of the current
// one sits in the output register and is being taken in that cycle, or has
// already gone; a stall on that last word holds the command input off.
// default_attr may only be written while no command is in flight.
// ----------------------------------------------------------------------------
module text_console_cursor_writer #(
    parameter int COLUMNS   = tccw_pkg::COLUMNS_DEF,
    parameter int ROW_COUNT = tccw_pkg::ROW_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  tccw_pkg::byte_t      cfg_data,
    tccw_cmd_if.sink             cmd,
    tccw_disp_if.source          disp
);
    import tccw_pkg::*;

    localparam int DIG_W = 4 * DIGITS_MAX;

    // sequencer codes
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CONV  = 2'd1;  // double-dabble, one bit a cycle
    localparam logic [1:0] S_STRIP = 2'd2;  // drop leading zero digits
    localparam logic [1:0] S_EMIT  = 2'd3;  // one character word a cycle while the output is free

    localparam logic [7:0] COLS_L     = 8'(COLUMNS);
    localparam logic [5:0] ROWS_L     = 6'(ROW_COUNT);
    localparam row_t       LAST_ROW   = ROW_W'(ROW_COUNT - 1);

    logic [1:0]       state_reg,  state_next;
    byte_t            attr_cfg_reg;
    col_t             col_reg,    col_next;
    row_t             row_reg,    row_next;
    logic [NUM_W-1:0] bin_reg,    bin_next;     // value still to shift into BCD
    logic [DIG_W-1:0] dig_reg,    dig_next;     // digit shift register, MSD on top
    logic [3:0]       cnt_reg,    cnt_next;     // digits left to send
    logic [4:0]       step_reg,   step_next;    // conversion bit index
    logic [1:0]       pf_reg,     pf_next;      // "0x" prefix characters left

    // output register
    logic   ov_reg,  ov_next;
    logic   owv_reg, owv_next;
    row_t   orow_reg, orow_next;
    col_t   ocol_reg, ocol_next;
    byte_t  oglyph_reg, oglyph_next;
    byte_t  oattr_reg, oattr_next;
    logic   oscr_reg, oscr_next;
    logic   oclr_reg, oclr_next;
    logic   olast_reg, olast_next;

    logic             out_free;
    logic             cmd_acc;
    logic [DIG_W-1:0] dab;
    nib_t             top_dig;

    // cursor move for one character
    byte_t      pc_ch;
    logic       pc_wv;
    logic       pc_scroll;
    logic [7:0] pc_c;
    logic [5:0] pc_r;
    col_t       pc_col;
    row_t       pc_row;
    byte_t      emit_ch;
    logic       emit_last;

    assign out_free  = !ov_reg || disp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && out_free;
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign top_dig   = dig_reg[DIG_W-1 -: 4];

    assign disp.valid       = ov_reg;
    assign disp.write_valid = owv_reg;
    assign disp.row         = orow_reg;
    assign disp.col         = ocol_reg;
    assign disp.glyph       = oglyph_reg;
    assign disp.attr        = oattr_reg;
    assign disp.scrolled    = oscr_reg;
    assign disp.cleared     = oclr_reg;
    assign disp.last        = olast_reg;

    // add 3 to every BCD digit of 5 or more before the shift; digits are independent
    always_comb
    begin
        for (int i = 0; i < DIGITS_MAX; i++)
        begin
            dab[4*i +: 4] = (dig_reg[4*i +: 4] >= 4'd5) ? dig_reg[4*i +: 4] + 4'd3
                                                        : dig_reg[4*i +: 4];
        end
    end

    // character of the current emit step
    always_comb
    begin
        case (pf_reg)
            2'd2:    emit_ch = CH_ZERO;
            2'd1:    emit_ch = CH_X;
            default: emit_ch = digit_char(top_dig);
        endcase
        emit_last = (pf_reg == 2'd0) && (cnt_reg == 4'd1);
    end

    assign pc_ch = (state_reg == S_IDLE) ? cmd.char_code : emit_ch;

    always_comb
    begin
        pc_c      = {1'b0, col_reg};
        pc_r      = {1'b0, row_reg};
        pc_wv     = 1'b0;
        pc_scroll = 1'b0;
        case (pc_ch)
            CH_NL:
            begin
                pc_c = 8'd0;
                pc_r = pc_r + 6'd1;
            end
            CH_CR:
            begin
                pc_c = 8'd0;
            end
            CH_TAB:
            begin
                pc_c = (pc_c + 8'd8) & 8'hF8;
            end
            default:
            begin
                pc_wv = 1'b1;
                pc_c  = pc_c + 8'd1;
            end
        endcase
        if (pc_c >= COLS_L)
        begin
            pc_c = 8'd0;
            pc_r = pc_r + 6'd1;
        end
        pc_col = pc_c[COL_W-1:0];
        pc_row = pc_r[ROW_W-1:0];
        if (pc_r >= ROWS_L)
        begin
            pc_scroll = 1'b1;
            pc_row    = LAST_ROW;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        bin_next    = bin_reg;
        dig_next    = dig_reg;
        cnt_next    = cnt_reg;
        step_next   = step_reg;
        pf_next     = pf_reg;
        ov_next     = ov_reg && !disp.ready;
        owv_next    = owv_reg;
        orow_next   = orow_reg;
        ocol_next   = ocol_reg;
        oglyph_next = oglyph_reg;
        oattr_next  = oattr_reg;
        oscr_next   = oscr_reg;
        oclr_next   = oclr_reg;
        olast_next  = olast_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    case (cmd.func)
                        FUNC_PUT:
                        begin
                            ov_next     = 1'b1;
                            owv_next    = pc_wv;
                            orow_next   = pc_wv ? row_reg : '0;
                            ocol_next   = pc_wv ? col_reg : '0;
                            oglyph_next = pc_wv ? cmd.char_code : 8'd0;
                            oattr_next  = pc_wv ? {cmd.bg, cmd.fg} : 8'd0;
                            oscr_next   = pc_scroll;
                            oclr_next   = 1'b0;
                            olast_next  = 1'b1;
                            col_next    = pc_col;
                            row_next    = pc_row;
                        end
                        FUNC_HEX:
                        begin
                            dig_next   = {cmd.number, {(DIG_W-NUM_W){1'b0}}};
                            cnt_next   = 4'd8;
                            pf_next    = 2'd2;
                            state_next = S_STRIP;
                        end
                        FUNC_DEC:
                        begin
                            bin_next   = cmd.number;
                            dig_next   = '0;
                            cnt_next   = 4'(DIGITS_MAX);
                            pf_next    = 2'd0;
                            step_next  = '0;
                            state_next = S_CONV;
                        end
                        default:
                        begin
                            // clear: blank screen, cursor home
                            ov_next     = 1'b1;
                            owv_next    = 1'b0;
                            orow_next   = '0;
                            ocol_next   = '0;
                            oglyph_next = CH_SPACE;
                            oattr_next  = attr_cfg_reg;
                            oscr_next   = 1'b0;
                            oclr_next   = 1'b1;
                            olast_next  = 1'b1;
                            col_next    = '0;
                            row_next    = '0;
                        end
                    endcase
                end
            end
            S_CONV:
            begin
                dig_next  = {dab[DIG_W-2:0], bin_reg[NUM_W-1]};
                bin_next  = {bin_reg[NUM_W-2:0], 1'b0};
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(NUM_W - 1))
                begin
                    state_next = S_STRIP;
                end
            end
            S_STRIP:
            begin
                if ((cnt_reg > 4'd1) && (top_dig == 4'd0))
                begin
                    dig_next = {dig_reg[DIG_W-5:0], 4'b0};
                    cnt_next = cnt_reg - 4'd1;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            default:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    owv_next    = pc_wv;
                    orow_next   = row_reg;
                    ocol_next   = col_reg;
                    oglyph_next = emit_ch;
                    oattr_next  = attr_cfg_reg;
                    oscr_next   = pc_scroll;
                    oclr_next   = 1'b0;
                    olast_next  = emit_last;
                    col_next    = pc_col;
                    row_next    = pc_row;
                    if (pf_reg != 2'd0)
                    begin
                        pf_next = pf_reg - 2'd1;
                    end
                    else
                    begin
                        dig_next = {dig_reg[DIG_W-5:0], 4'b0};
                        cnt_next = cnt_reg - 4'd1;
                    end
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            attr_cfg_reg <= ATTR_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            ov_reg       <= 1'b0;
            cnt_reg      <= '0;
            step_reg     <= '0;
            pf_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                attr_cfg_reg <= cfg_data;
            end
            col_reg  <= col_next;
            row_reg  <= row_next;
            ov_reg   <= ov_next;
            cnt_reg  <= cnt_next;
            step_reg <= step_next;
            pf_reg   <= pf_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        bin_reg    <= bin_next;
        dig_reg    <= dig_next;
        owv_reg    <= owv_next;
        orow_reg   <= orow_next;
        ocol_reg   <= ocol_next;
        oglyph_reg <= oglyph_next;
        oattr_reg  <= oattr_next;
        oscr_reg   <= oscr_next;
        oclr_reg   <= oclr_next;
        olast_reg  <= olast_next;
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
`include "assert_macros.svh"

    `ASSERT_CLK(a_cursor_range, ({1'b0, col_reg} < COLS_L) && ({1'b0, row_reg} < ROWS_L), "cursor out of grid")
    `ASSERT_CLK(a_clear_word, !(ov_reg && oclr_reg) || (olast_reg && !owv_reg), "clear word malformed")
    `ASSERT_CLK(a_emit_count, (state_reg != S_EMIT) || (cnt_reg != 4'd0), "emit with no digits left")
    `ASSERT_NEXT(a_clear_home, cmd_acc && (cmd.func == FUNC_CLEAR), (col_reg == '0) && (row_reg == '0), "clear did not home cursor")

endmodule

### sim/cell_write_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_write_checker
// Watches the command and display channels of the console cursor writer.
// Keeps its own cursor and fill attribute, works out the cell-write words that
// each accepted command word must give, and compares each display word taken
// with the oldest one still due.
// ----------------------------------------------------------------------------
module cell_write_checker #(
    parameter int COLUMNS   = tccw_pkg::COLUMNS_DEF,
    parameter int ROW_COUNT = tccw_pkg::ROW_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  tccw_pkg::byte_t cfg_data,
    tccw_cmd_if             cmd,
    tccw_disp_if            disp,
    output int              fail_count,
    output int              words_pending
);
    import tccw_pkg::*;

    typedef struct packed {
        logic   write_valid;
        row_t   row;
        col_t   col;
        byte_t  glyph;
        byte_t  attr;
        logic   scrolled;
        logic   cleared;
        logic   last;
    } cell_word_t;

    int         cur_col    = 0;
    int         cur_row    = 0;
    byte_t      fill_attr  = ATTR_RESET;
    int         mismatches = 0;
    int         due_count  = 0;
    cell_word_t cell_words_due[$];

    assign fail_count    = mismatches;
    assign words_pending = due_count;

    // One character through the cursor: control codes only move it.
    function automatic cell_word_t place_glyph(byte_t c, byte_t a);
        cell_word_t w;
        w = '0;
        if (c == CH_NL) begin
            cur_col = 0;
            cur_row++;
        end else if (c == CH_CR) begin
            cur_col = 0;
        end else if (c == CH_TAB) begin
            cur_col = (cur_col + 8) & ~7;
        end else begin
            w.write_valid = 1'b1;
            w.row         = row_t'(cur_row);
            w.col         = col_t'(cur_col);
            w.glyph       = c;
            w.attr        = a;
            cur_col++;
        end
        if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= ROW_COUNT) begin
            w.scrolled = 1'b1;
            cur_row    = ROW_COUNT - 1;
        end
        return w;
    endfunction

    task automatic predict_cell_words(func_t f, byte_t ch, nib_t fg, nib_t bg,
                                      logic [NUM_W-1:0] num);
        cell_word_t       words [DIGITS_MAX + 2];
        nib_t             digits [DIGITS_MAX];
        int               n;
        int               nd;
        logic [NUM_W-1:0] v;
        n  = 0;
        nd = 0;
        case (f)
            FUNC_PUT: begin
                words[n] = place_glyph(ch, {bg, fg});
                n++;
            end
            FUNC_HEX: begin
                for (int i = 0; i < 8; i++)
                    digits[i] = num[4*i +: 4];
                nd = 8;
                while (nd > 1 && digits[nd-1] == 4'd0)
                    nd--;
                words[n] = place_glyph(CH_ZERO, fill_attr);
                n++;
                words[n] = place_glyph(CH_X, fill_attr);
                n++;
                for (int i = nd - 1; i >= 0; i--) begin
                    words[n] = place_glyph(HEX_CHARS[digits[i]], fill_attr);
                    n++;
                end
            end
            FUNC_DEC: begin
                v = num;
                do begin
                    digits[nd] = nib_t'(v % 10);
                    v          = v / 10;
                    nd++;
                end while (v != 0 && nd < DIGITS_MAX);
                for (int i = nd - 1; i >= 0; i--) begin
                    words[n] = place_glyph(byte_t'(CH_ZERO + digits[i]), fill_attr);
                    n++;
                end
            end
            FUNC_CLEAR: begin
                words[n]         = '0;
                words[n].glyph   = CH_SPACE;
                words[n].attr    = fill_attr;
                words[n].cleared = 1'b1;
                cur_col          = 0;
                cur_row          = 0;
                n++;
            end
        endcase
        words[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            cell_words_due.push_back(words[i]);
    endtask

    function automatic void compare_field(string name, int unsigned want,
                                          int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        cell_word_t want;
        if (!rst_n) begin
            cur_col   = 0;
            cur_row   = 0;
            fill_attr = ATTR_RESET;
            cell_words_due.delete();
            due_count = 0;
        end else begin
            if (cfg_we)
                fill_attr = cfg_data;
            if (cmd.valid && cmd.ready)
                predict_cell_words(cmd.func, cmd.char_code, cmd.fg, cmd.bg, cmd.number);
            if (disp.valid && disp.ready) begin
                if (cell_words_due.size() == 0) begin
                    $display("%0t: display word expected none, actual glyph %0d row %0d col %0d",
                             $time, disp.glyph, disp.row, disp.col);
                    mismatches++;
                end else begin
                    want = cell_words_due.pop_front();
                    compare_field("write_valid", want.write_valid, disp.write_valid);
                    compare_field("row", want.row, disp.row);
                    compare_field("col", want.col, disp.col);
                    compare_field("glyph", want.glyph, disp.glyph);
                    compare_field("attr", want.attr, disp.attr);
                    compare_field("scrolled", want.scrolled, disp.scrolled);
                    compare_field("cleared", want.cleared, disp.cleared);
                    compare_field("last", want.last, disp.last);
                end
            end
            due_count = cell_words_due.size();
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the text console cursor writer.
// ----------------------------------------------------------------------------
// Drives command words into the console engine and takes its display words,
// both sides idling in random bursts. A directed set covers the extremes of
// every field, each function, control codes, zero prints and a tab wrap; then
// random phases run under several fill attributes, one of them heavy on
// newlines so the screen scrolls, one with a long display stall so the engine
// backs up onto its command input, and a last one with no idling. Checking is
// done by cell_write_checker, which hands back a failure count.
// ----------------------------------------------------------------------------
module tb_top;
    import tccw_pkg::*;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   cfg_we;
    byte_t  cfg_data;
    int     fail_count;
    int     words_due;

    // Flow controls set by the stimulus; rx_gaps and squeeze_req drive the display side
    bit     tx_gaps;
    bit     rx_gaps;
    bit     squeeze_req;

    tccw_cmd_if  cmd_ch ();
    tccw_disp_if disp_ch ();

    text_console_cursor_writer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd_ch),
        .disp     (disp_ch)
    );

    cell_write_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .cmd           (cmd_ch),
        .disp          (disp_ch),
        .fail_count    (fail_count),
        .words_pending (words_due)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop, well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Offer one command word and hold it until taken. Entered and left at a
    // rising edge, so valid sees a single assignment per step and stays high
    // across back-to-back words.
    task automatic send_cmd(func_t f, byte_t ch, nib_t fg, nib_t bg,
                            logic [NUM_W-1:0] num);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.func      <= f;
        cmd_ch.char_code <= ch;
        cmd_ch.fg        <= fg;
        cmd_ch.bg        <= bg;
        cmd_ch.number    <= num;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    // Random command: nl_pct percent newlines, the rest spread over the other
    // functions; clear is kept rare so the cursor gets far down the screen.
    task automatic send_random_cmd(int nl_pct);
        func_t            f;
        byte_t            ch;
        logic [NUM_W-1:0] num;
        f  = FUNC_PUT;
        ch = byte_t'($urandom);
        case ($urandom_range(0, 3))
            0: num = $urandom_range(0, 15);
            1: num = $urandom_range(0, 99999);
            2: num = 32'd1 << $urandom_range(0, 31);
            default: num = $urandom;
        endcase
        if ($urandom_range(0, 99) < nl_pct) begin
            ch = CH_NL;
        end else begin
            case ($urandom_range(0, 15))
                0: ch = CH_TAB;
                1: ch = CH_CR;
                7, 8, 9, 10: f = FUNC_HEX;
                11, 12, 13, 14: f = FUNC_DEC;
                15: if ($urandom_range(0, 7) == 0) f = FUNC_CLEAR;
                default: ;
            endcase
        end
        send_cmd(f, ch, nib_t'($urandom), nib_t'($urandom), num);
    endtask

    // Drop valid and wait until every display word due has been taken.
    // Pending count is looked at on the falling edge, clear of the updates.
    task automatic drain_console();
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
        while (words_due != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // New fill attribute, written only with the engine idle
    task automatic reconfigure(byte_t a);
        drain_console();
        repeat (8) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= a;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_data          = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.func       = FUNC_PUT;
        cmd_ch.char_code  = '0;
        cmd_ch.fg         = '0;
        cmd_ch.bg         = '0;
        cmd_ch.number     = '0;
        disp_ch.ready     = 1'b0;
        tx_gaps           = 1'b0;
        rx_gaps           = 1'b1;
        squeeze_req       = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Display side: bursts of stall, plus one long hold when asked so
        // the engine fills up and stops taking command words.
        fork
            forever begin
                if (squeeze_req) begin
                    squeeze_req = 1'b0;
                    disp_ch.ready <= 1'b0;
                    repeat (300) @(posedge clk);
                end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
                    disp_ch.ready <= 1'b0;
                    repeat ($urandom_range(1, 10)) @(posedge clk);
                end else begin
                    disp_ch.ready <= 1'b1;
                    @(posedge clk);
                end
            end
        join_none

        // Directed words at the reset attribute
        send_cmd(FUNC_PUT, 8'h41, 4'hF, 4'h0, 32'h0);
        send_cmd(FUNC_PUT, 8'h00, 4'h0, 4'hF, 32'hFFFF_FFFF);
        send_cmd(FUNC_PUT, 8'hFF, 4'hF, 4'hF, 32'h0);
        send_cmd(FUNC_PUT, CH_CR, 4'hA, 4'h5, 32'h0);
        send_cmd(FUNC_PUT, CH_NL, 4'h5, 4'hA, 32'h0);
        send_cmd(FUNC_HEX, 8'h00, 4'h0, 4'h0, 32'h0);          // 0x0
        send_cmd(FUNC_HEX, 8'hFF, 4'hF, 4'hF, 32'hFFFF_FFFF);
        send_cmd(FUNC_HEX, 8'h00, 4'h0, 4'h0, 32'h8000_0000);
        send_cmd(FUNC_DEC, 8'h00, 4'h0, 4'h0, 32'h0);          // single 0
        send_cmd(FUNC_DEC, 8'h00, 4'h0, 4'h0, 32'hFFFF_FFFF);  // ten digits
        send_cmd(FUNC_DEC, 8'h00, 4'h0, 4'h0, 32'd1_000_000_000);
        send_cmd(FUNC_CLEAR, 8'hFF, 4'hF, 4'hF, 32'hFFFF_FFFF);
        // From home, the tenth tab runs off the row and wraps
        repeat (10)
            send_cmd(FUNC_PUT, CH_TAB, 4'h3, 4'hC, 32'h0);

        // Mixed traffic, gaps on both sides
        tx_gaps = 1'b1;
        reconfigure(8'hFF);
        repeat (40) send_random_cmd(15);

        // Newline heavy, so the cursor reaches the last row and scrolls
        reconfigure(8'h00);
        repeat (40) send_random_cmd(45);

        // Long display stall while command words keep coming
        reconfigure(byte_t'($urandom));
        tx_gaps     = 1'b0;
        squeeze_req = 1'b1;
        repeat (40) send_random_cmd(20);

        // Final stretch at full rate, no idling anywhere
        reconfigure(byte_t'($urandom));
        rx_gaps = 1'b0;
        repeat (30) send_random_cmd(20);

        drain_console();
        repeat (64) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/tccw_pkg.sv
rtl/tccw_cmd_if.sv
rtl/tccw_disp_if.sv
rtl/text_console_cursor_writer.sv
sim/cell_write_checker.sv
sim/tb_top.sv
